// ----- src/lrba_pkg.sv -----
// Shared types and constants for the LED region brightness averager.
// No dependencies; every other file refers to it by scoped names.
package lrba_pkg;

  localparam int NUM_LEDS     = 256;
  localparam int FRAME_WIDTH  = 1024;
  localparam int FRAME_HEIGHT = 256;

  localparam int LED_W   = 8;
  localparam int COL_W   = 10;
  localparam int ROW_W   = 8;
  localparam int LVL_W   = 8;
  localparam int SUM_W   = 26;
  localparam int TALLY_W = 19;
  localparam int QUO_W   = 8;

  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

  // floor(t/3) == (t * DIV3_MUL) >> DIV3_SHIFT for every t below 2048
  localparam logic [9:0] DIV3_MUL   = 10'd683;
  localparam int         DIV3_SHIFT = 11;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_PIXEL = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  typedef struct packed {
    logic [COL_W-1:0] left;
    logic [COL_W-1:0] right;
    logic [ROW_W-1:0] top;
    logic [ROW_W-1:0] bottom;
  } rect_t;

  // One item as it travels down the cell chain.
  typedef struct packed {
    logic               vld;
    logic [1:0]         action;
    logic               pix_en;
    logic [LED_W-1:0]   led;
    rect_t              rect;
    logic [LVL_W-1:0]   level;
    logic [COL_W-1:0]   x;
    logic [ROW_W-1:0]   y;
    logic [SUM_W-1:0]   rd_sum;
    logic [TALLY_W-1:0] rd_cnt;
  } chain_item_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

  typedef struct packed {
    logic idle;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic [LED_W-1:0]   led;
    logic [QUO_W-1:0]   avg;
    logic [TALLY_W-1:0] cnt;
  } div_res_t;

endpackage

// ----- src/lrba_in_if.sv -----
// Input item channel: valid/ready plus load, pixel and read fields.
// Depends on lrba_pkg for field widths.
interface lrba_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   action;
  logic [lrba_pkg::LED_W-1:0]   led_index;
  logic [lrba_pkg::COL_W-1:0]   rect_left;
  logic [lrba_pkg::COL_W-1:0]   rect_right;
  logic [lrba_pkg::ROW_W-1:0]   rect_top;
  logic [lrba_pkg::ROW_W-1:0]   rect_bottom;
  logic [7:0]                   red;
  logic [7:0]                   green;
  logic [7:0]                   blue;
  logic [lrba_pkg::COL_W-1:0]   pixel_x;
  logic [lrba_pkg::ROW_W-1:0]   pixel_y;

  modport source (
    output valid, action, led_index, rect_left, rect_right, rect_top, rect_bottom,
           red, green, blue, pixel_x, pixel_y,
    input  ready
  );
  modport sink (
    input  valid, action, led_index, rect_left, rect_right, rect_top, rect_bottom,
           red, green, blue, pixel_x, pixel_y,
    output ready
  );
endinterface

// ----- src/lrba_out_if.sv -----
// Result item channel: valid/ready plus LED number, average and pixel count.
// Depends on lrba_pkg for field widths.
interface lrba_out_if;
  logic                         valid;
  logic                         ready;
  logic [lrba_pkg::LED_W-1:0]   led_number;
  logic [lrba_pkg::QUO_W-1:0]   average_level;
  logic [lrba_pkg::TALLY_W-1:0] covered_pixels;

  modport source (
    output valid, led_number, average_level, covered_pixels,
    input  ready
  );
  modport sink (
    input  valid, led_number, average_level, covered_pixels,
    output ready
  );
endinterface

// ----- src/lrba_cfg_if.sv -----
// Configuration write channel for the brightness cap register.
// Depends on lrba_pkg for the data width.
interface lrba_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [lrba_pkg::LVL_W-1:0] max_brightness;

  modport source (output valid, max_brightness, input ready);
  modport sink (input valid, max_brightness, output ready);
endinterface

// ----- src/lrba_cell.sv -----
// One LED cell: rectangle, valid bit, brightness sum and pixel tally.
// Registers the passing item for the next cell. Depends on lrba_pkg.
module lrba_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic [lrba_pkg::LED_W-1:0]   cell_id,
  input  lrba_pkg::chain_item_t        item_i,
  output lrba_pkg::chain_item_t        item_o
);

  logic                         vld_r, vld_nxt;
  lrba_pkg::rect_t              rect_r, rect_nxt;
  logic [lrba_pkg::SUM_W-1:0]   sum_r, sum_nxt;
  logic [lrba_pkg::TALLY_W-1:0] tally_r, tally_nxt;
  lrba_pkg::chain_item_t        item_r, item_nxt;

  logic                         hit;
  logic                         in_rect;
  logic [lrba_pkg::SUM_W:0]     sum_ext;

  assign hit     = item_i.vld && (item_i.led == cell_id);
  assign in_rect = (item_i.x >= rect_r.left) && (item_i.x <= rect_r.right) &&
                   (item_i.y >= rect_r.top) && (item_i.y <= rect_r.bottom);
  assign sum_ext = {1'b0, sum_r} + (lrba_pkg::SUM_W+1)'(item_i.level);

  always_comb begin
    vld_nxt   = vld_r;
    rect_nxt  = rect_r;
    sum_nxt   = sum_r;
    tally_nxt = tally_r;
    item_nxt  = item_i;
    case (item_i.action)
      lrba_pkg::ACT_LOAD: begin
        if (hit) begin
          rect_nxt = item_i.rect;
          vld_nxt  = 1'b1;
        end
      end
      lrba_pkg::ACT_PIXEL: begin
        // skip the pixel once either accumulator would overflow
        if (item_i.vld && item_i.pix_en && vld_r && in_rect &&
            tally_r != lrba_pkg::TALLY_MAX &&
            sum_ext <= {1'b0, lrba_pkg::SUM_MAX}) begin
          sum_nxt   = sum_ext[lrba_pkg::SUM_W-1:0];
          tally_nxt = tally_r + 1'b1;
        end
      end
      lrba_pkg::ACT_READ: begin
        if (hit) begin
          item_nxt.rd_sum = sum_r;
          item_nxt.rd_cnt = tally_r;
          sum_nxt         = '0;
          tally_nxt       = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= 1'b0;
      sum_r      <= '0;
      tally_r    <= '0;
      item_r.vld <= 1'b0;
    end else if (adv) begin
      vld_r   <= vld_nxt;
      sum_r   <= sum_nxt;
      tally_r <= tally_nxt;
      item_r  <= item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rect_r <= rect_nxt;
    end
  end

  assign item_o = item_r;

endmodule

// ----- src/lrba_div.sv -----
// Radix-2 restoring divider for the read average, one quotient bit a cycle,
// holding its result until the output side takes it. Depends on lrba_pkg.
module lrba_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [lrba_pkg::LED_W-1:0]   led,
  input  logic [lrba_pkg::SUM_W-1:0]   sum,
  input  logic [lrba_pkg::TALLY_W-1:0] cnt,
  input  logic                         res_ready,
  output lrba_pkg::div_stat_t          stat,
  output logic                         res_valid,
  output lrba_pkg::div_res_t           res
);

  localparam int STEP_W = $clog2(lrba_pkg::QUO_W);
  localparam int PRE    = lrba_pkg::QUO_W - 1;

  lrba_pkg::div_state_t         state_r, state_nxt;
  logic [STEP_W-1:0]            step_r;
  logic [lrba_pkg::SUM_W-1:0]   rem_r;
  logic [lrba_pkg::SUM_W-1:0]   den_r;
  logic [lrba_pkg::QUO_W-1:0]   quo_r;
  logic [lrba_pkg::TALLY_W-1:0] cnt_r;
  logic [lrba_pkg::LED_W-1:0]   led_r;
  logic                         fits;

  assign fits = (rem_r >= den_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lrba_pkg::DIV_IDLE: if (start) state_nxt = lrba_pkg::DIV_RUN;
      lrba_pkg::DIV_RUN:  if (step_r == '0) state_nxt = lrba_pkg::DIV_DONE;
      lrba_pkg::DIV_DONE: begin
        if (res_ready) state_nxt = start ? lrba_pkg::DIV_RUN : lrba_pkg::DIV_IDLE;
      end
      default: state_nxt = lrba_pkg::DIV_IDLE;
    endcase
  end

  always_comb begin
    stat.idle = 1'b0;
    stat.done = 1'b0;
    unique case (state_r)
      lrba_pkg::DIV_IDLE: stat.idle = 1'b1;
      lrba_pkg::DIV_RUN:  ;
      lrba_pkg::DIV_DONE: stat.done = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lrba_pkg::DIV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= sum;
      den_r  <= {cnt, PRE'(0)};
      quo_r  <= '0;
      step_r <= STEP_W'(PRE);
      cnt_r  <= cnt;
      led_r  <= led;
    end else if (state_r == lrba_pkg::DIV_RUN) begin
      if (fits) begin
        rem_r <= rem_r - den_r;
      end
      quo_r  <= {quo_r[lrba_pkg::QUO_W-2:0], fits};
      den_r  <= den_r >> 1;
      step_r <= step_r - 1'b1;
    end
  end

  assign res_valid = stat.done;
  assign res.led   = led_r;
  // an empty tally divides to all ones; report zero instead
  assign res.avg   = (cnt_r == '0) ? '0 : quo_r;
  assign res.cnt   = cnt_r;

endmodule

// ----- src/led_region_brightness_average_core.sv -----
// Top level of the LED region brightness averager: input level math, the
// chain of LED cells and the read divider. Depends on lrba_pkg, the channel
// interfaces, lrba_cell and lrba_div.
//
//   port     dir  role
//   in_ch    in   load rectangle / accumulate pixel / read-and-clear items
//   out_ch   out  one result item per read
//   cfg_ch   in   max_brightness cap
//
// Each item walks the row of 256 cells, one cell per cycle unless the chain
// is held, and a read's result leaves from the divider. Loads and pixels enter one
// per cycle; a read holds the chain while the 8-step divider is busy and
// while its result waits at the output. Reset clears valid bits, sums and
// tallies at once; rectangles need no clearing.
module led_region_brightness_average_core (
  input  logic              clk,
  input  logic              rst_n,
  lrba_in_if.sink           in_ch,
  lrba_out_if.source        out_ch,
  lrba_cfg_if.sink          cfg_ch
);

  logic [lrba_pkg::LVL_W-1:0] max_bright_r;
  logic [9:0]                 total;
  logic [19:0]                prod;
  logic [lrba_pkg::LVL_W-1:0] raw_level;
  logic                       in_frame;
  logic                       adv;
  logic                       tail_read;
  logic                       div_start;
  lrba_pkg::chain_item_t      head_item;
  lrba_pkg::chain_item_t      chain [lrba_pkg::NUM_LEDS+1];
  lrba_pkg::div_stat_t        div_stat;
  lrba_pkg::div_res_t         div_res;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bright_r <= '1;
    end else if (cfg_ch.valid) begin
      max_bright_r <= cfg_ch.max_brightness;
    end
  end

  // brightness = floor((r+g+b)/3) by reciprocal multiply, then cap
  assign total     = 10'(in_ch.red) + 10'(in_ch.green) + 10'(in_ch.blue);
  assign prod      = 20'(total) * 20'(lrba_pkg::DIV3_MUL);
  assign raw_level = prod[lrba_pkg::DIV3_SHIFT +: lrba_pkg::LVL_W];
  assign in_frame  = (32'(in_ch.pixel_x) < lrba_pkg::FRAME_WIDTH) &&
                     (32'(in_ch.pixel_y) < lrba_pkg::FRAME_HEIGHT);

  always_comb begin
    head_item.vld         = in_ch.valid;
    head_item.action      = in_ch.action;
    head_item.pix_en      = (in_ch.action == lrba_pkg::ACT_PIXEL) && in_frame;
    head_item.led         = in_ch.led_index;
    head_item.rect.left   = in_ch.rect_left;
    head_item.rect.right  = in_ch.rect_right;
    head_item.rect.top    = in_ch.rect_top;
    head_item.rect.bottom = in_ch.rect_bottom;
    head_item.level       = (raw_level > max_bright_r) ? max_bright_r : raw_level;
    head_item.x           = in_ch.pixel_x;
    head_item.y           = in_ch.pixel_y;
    head_item.rd_sum      = '0;
    head_item.rd_cnt      = '0;
  end

  assign chain[0] = head_item;

  for (genvar k = 0; k < lrba_pkg::NUM_LEDS; k++) begin : g_cell
    lrba_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .cell_id (lrba_pkg::LED_W'(k)),
      .item_i  (chain[k]),
      .item_o  (chain[k+1])
    );
  end

  // non-read items drop off the tail; a read waits for the divider
  assign tail_read = chain[lrba_pkg::NUM_LEDS].vld &&
                     (chain[lrba_pkg::NUM_LEDS].action == lrba_pkg::ACT_READ);
  assign adv       = !tail_read || div_stat.idle || (div_stat.done && out_ch.ready);
  assign div_start = tail_read && adv;
  assign in_ch.ready = adv;

  lrba_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .led       (chain[lrba_pkg::NUM_LEDS].led),
    .sum       (chain[lrba_pkg::NUM_LEDS].rd_sum),
    .cnt       (chain[lrba_pkg::NUM_LEDS].rd_cnt),
    .res_ready (out_ch.ready),
    .stat      (div_stat),
    .res_valid (out_ch.valid),
    .res       (div_res)
  );

  assign out_ch.led_number     = div_res.led;
  assign out_ch.average_level  = div_res.avg;
  assign out_ch.covered_pixels = div_res.cnt;

  a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (div_stat.idle || (div_stat.done && out_ch.ready)))
    else $error("divider started while holding an untaken result");

  a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> ##9 out_ch.valid)
    else $error("read result not ready after the divide steps");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.covered_pixels == '0) |-> (out_ch.average_level == '0))
    else $error("nonzero average reported for an LED with no pixels");

endmodule
